// File: rtl/sbl_pkg.sv
// ----------------------------------------------------------------------------
// sbl_pkg
// Shared types and constants of the Sobel edge magnitude stream unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sbl_pkg;

   typedef logic [7:0] pixel_type;

   // One line store word: the two rows above the current input row
   typedef struct packed {
      pixel_type older;
      pixel_type newer;
   } line_word_type;

   // Left (c-2) and middle (c-1) columns of the 3x3 neighborhood
   typedef struct packed {
      pixel_type tl;
      pixel_type ml;
      pixel_type bl;
      pixel_type tm;
      pixel_type mm;
      pixel_type bm;
   } window_type;

   // What one input pixel produces on the result side
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_ZERO,
      KIND_MAG,
      KIND_PAIR
   } kind_type;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic REG_LINE_WIDTH   = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic [10:0] LINE_WIDTH_RESET   = 11'd640;
   localparam logic [12:0] FRAME_HEIGHT_RESET = 13'd480;
   localparam logic [12:0] HEIGHT_LIMIT       = 13'd4096;

   localparam pixel_type PIXEL_MAX = 8'd255;

endpackage : sbl_pkg

`default_nettype wire

// File: rtl/sbl_req_if.sv
// ----------------------------------------------------------------------------
// sbl_req_if
// Input pixel channel: valid/ready handshake with one grey pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbl_req_if;
   logic               valid;
   logic               ready;
   sbl_pkg::pixel_type pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface : sbl_req_if

`default_nettype wire

// File: rtl/sbl_rsp_if.sv
// ----------------------------------------------------------------------------
// sbl_rsp_if
// Result channel: valid/ready handshake with edge magnitude and row flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbl_rsp_if;
   logic               valid;
   logic               ready;
   sbl_pkg::pixel_type pixel_out;
   logic               row_end;
   logic               frame_end;
   logic               last_of_run;

   modport source (output valid, output pixel_out, output row_end, output frame_end,
                   output last_of_run, input ready);
   modport sink   (input valid, input pixel_out, input row_end, input frame_end,
                   input last_of_run, output ready);
endinterface : sbl_rsp_if

`default_nettype wire

// File: rtl/sbl_line_store.sv
// ----------------------------------------------------------------------------
// sbl_line_store
// Two line buffers in one memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_line_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  wire logic                   clock,
   input  wire logic                   rd_en,
   input  wire logic [ADDR_W-1:0]      rd_addr,
   output      sbl_pkg::line_word_type rd_data,
   input  wire logic                   wr_en,
   input  wire logic [ADDR_W-1:0]      wr_addr,
   input  wire sbl_pkg::line_word_type wr_data
);
   import sbl_pkg::*;

   line_word_type mem [DEPTH];
   line_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data while the reader stalls
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : sbl_line_store

`default_nettype wire

// File: rtl/sbl_kernel.sv
// ----------------------------------------------------------------------------
// sbl_kernel
// 3x3 Sobel operator: |Gx| + |Gy|, saturated to 8 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_kernel (
   input  wire sbl_pkg::window_type win,
   input  wire sbl_pkg::pixel_type  col_top,
   input  wire sbl_pkg::pixel_type  col_mid,
   input  wire sbl_pkg::pixel_type  col_bot,
   output      sbl_pkg::pixel_type  magnitude
);
   import sbl_pkg::*;

   logic [9:0]  gx_pos;
   logic [9:0]  gx_neg;
   logic [9:0]  gy_pos;
   logic [9:0]  gy_neg;
   logic [9:0]  gx_abs;
   logic [9:0]  gy_abs;
   logic [10:0] sum;

   always_comb begin
      gx_pos = 10'(col_top) + {1'b0, col_mid, 1'b0} + 10'(col_bot);
      gx_neg = 10'(win.tl) + {1'b0, win.ml, 1'b0} + 10'(win.bl);
      gy_pos = 10'(win.tl) + {1'b0, win.tm, 1'b0} + 10'(col_top);
      gy_neg = 10'(win.bl) + {1'b0, win.bm, 1'b0} + 10'(col_bot);
      // larger minus smaller gives the absolute difference
      gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
      gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
      sum    = 11'(gx_abs) + 11'(gy_abs);
      magnitude = (sum > 11'(PIXEL_MAX)) ? PIXEL_MAX : sum[7:0];
   end

endmodule : sbl_kernel

`default_nettype wire

// File: rtl/sobel_edge_magnitude_stream_unit.sv
// A pixel waits in the input stage register until the result stage can take it.
// Throughput: one pixel per cycle while results are taken; an output row's last
//   column gives two results and holds the input (one result port beat each).
// Reset: synchronous, active high; clears the pipeline and counters and loads
//   line_width 640, frame_height 480. Line store contents are not cleared.
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_stream_unit
// Raster pixel stream in, Sobel L1 edge magnitude out, one row behind.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude_stream_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   sbl_req_if.sink                                     req_ch,
   sbl_rsp_if.source                                   rsp_ch,
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [sbl_pkg::CSR_ADDR_W-1:0]         paddr,
   input  wire logic [sbl_pkg::CSR_DATA_W-1:0]         pwdata,
   output      logic [sbl_pkg::CSR_DATA_W-1:0]         prdata,
   output      logic                                   pready
);
   import sbl_pkg::*;

   localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);

   // configuration
   logic [10:0] line_width_ff;
   logic [12:0] frame_height_ff;
   logic        csr_write;
   logic [12:0] width_ext;
   logic [12:0] width_eff;
   logic [12:0] height_eff;
   logic [WW-1:0] col_last;
   logic [11:0] row_last;

   // position counters
   logic [CW-1:0] col_ff;
   logic [CW-1:0] col_in;
   logic [11:0]   row_ff;
   logic [11:0]   row_in;
   logic [WW-1:0] col_ext;

   // input stage
   logic          req_fire;
   logic          a_valid_ff;
   logic          a_valid_in;
   pixel_type     a_pixel_ff;
   logic [CW-1:0] a_col_ff;
   kind_type      a_kind_ff;
   kind_type      kind_in;
   logic          a_fe_ff;
   logic          a_adv;

   line_word_type rd_word;
   line_word_type wr_word;
   window_type    win_ff;
   window_type    win_in;
   pixel_type     magnitude;

   // result stage
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   pixel_type  head_pixel_ff;
   pixel_type  head_pixel_in;
   logic       head_re_ff;
   logic       head_re_in;
   logic       head_fe_ff;
   logic       head_fe_in;
   logic       head_last_ff;
   logic       head_last_in;
   logic       tail_fe_ff;
   logic       tail_fe_in;
   logic       rsp_fire;
   logic       out_free;
   logic       load;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_LINE_WIDTH:   line_width_ff   <= pwdata[10:0];
            REG_FRAME_HEIGHT: frame_height_ff <= pwdata[12:0];
            default:          line_width_ff   <= line_width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_LINE_WIDTH:   prdata = CSR_DATA_W'(line_width_ff);
         REG_FRAME_HEIGHT: prdata = CSR_DATA_W'(frame_height_ff);
         default:          prdata = '0;
      endcase
   end

   // clamp the geometry to the supported range
   always_comb begin
      width_ext = 13'(line_width_ff);
      if (width_ext < 13'd3) begin
         width_eff = 13'd3;
      end else if (width_ext > 13'(MAX_WIDTH)) begin
         width_eff = 13'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      if (frame_height_ff < 13'd3) begin
         height_eff = 13'd3;
      end else if (frame_height_ff > HEIGHT_LIMIT) begin
         height_eff = HEIGHT_LIMIT;
      end else begin
         height_eff = frame_height_ff;
      end
      col_last = width_eff[WW-1:0] - WW'(1);
      row_last = 12'(height_eff - 13'd1);
   end

   // ---------------- position and emission kind ----------------
   assign req_fire = req_ch.valid & req_ch.ready;
   assign col_ext  = WW'(col_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (col_ext == col_last) begin
            col_in = '0;
            row_in = (row_ff == row_last) ? 12'd0 : row_ff + 12'd1;
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      priority if (row_ff < 12'd2) begin
         kind_in = KIND_NONE;
      end else if (col_ff == '0) begin
         kind_in = KIND_ZERO;
      end else if (col_ext == col_last) begin
         kind_in = KIND_PAIR;
      end else if (col_ext >= WW'(2)) begin
         kind_in = KIND_MAG;
      end else begin
         kind_in = KIND_NONE;
      end
   end

   // a register write restarts the frame
   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------- input stage ----------------
   assign out_free     = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ch.ready);
   assign a_adv        = a_valid_ff && ((a_kind_ff == KIND_NONE) || out_free);
   assign req_ch.ready = !a_valid_ff || a_adv;
   assign a_valid_in   = req_fire || (a_valid_ff && !a_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_pixel_ff <= req_ch.pixel_in;
         a_col_ff   <= col_ff;
         a_kind_ff  <= kind_in;
         a_fe_ff    <= (row_ff == row_last);
      end
   end

   sbl_line_store #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (CW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (rd_word),
      .wr_en   (a_adv),
      .wr_addr (a_col_ff),
      .wr_data (wr_word)
   );

   // shift both rows up one line at this column
   assign wr_word.older = rd_word.newer;
   assign wr_word.newer = a_pixel_ff;

   sbl_kernel u_kernel (
      .win       (win_ff),
      .col_top   (rd_word.older),
      .col_mid   (rd_word.newer),
      .col_bot   (a_pixel_ff),
      .magnitude (magnitude)
   );

   always_comb begin
      win_in = win_ff;
      if (a_adv) begin
         win_in.tl = win_ff.tm;
         win_in.ml = win_ff.mm;
         win_in.bl = win_ff.bm;
         win_in.tm = rd_word.older;
         win_in.mm = rd_word.newer;
         win_in.bm = a_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else begin
         win_ff <= win_in;
      end
   end

   // ---------------- result stage ----------------
   assign rsp_fire = rsp_ch.valid & rsp_ch.ready;
   assign load     = a_adv && (a_kind_ff != KIND_NONE);

   always_comb begin
      cnt_in        = cnt_ff;
      head_pixel_in = head_pixel_ff;
      head_re_in    = head_re_ff;
      head_fe_in    = head_fe_ff;
      head_last_in  = head_last_ff;
      tail_fe_in    = tail_fe_ff;
      priority if (load) begin
         cnt_in        = (a_kind_ff == KIND_PAIR) ? 2'd2 : 2'd1;
         head_pixel_in = (a_kind_ff == KIND_ZERO) ? '0 : magnitude;
         head_re_in    = 1'b0;
         head_fe_in    = 1'b0;
         head_last_in  = (a_kind_ff != KIND_PAIR);
         tail_fe_in    = a_fe_ff;
      end else if (rsp_fire) begin
         if (cnt_ff == 2'd2) begin
            // advance to the zero right border pixel
            cnt_in        = 2'd1;
            head_pixel_in = '0;
            head_re_in    = 1'b1;
            head_fe_in    = tail_fe_ff;
            head_last_in  = 1'b1;
         end else begin
            cnt_in = 2'd0;
         end
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_pixel_ff <= head_pixel_in;
      head_re_ff    <= head_re_in;
      head_fe_ff    <= head_fe_in;
      head_last_ff  <= head_last_in;
      tail_fe_ff    <= tail_fe_in;
   end

   assign rsp_ch.valid       = (cnt_ff != 2'd0);
   assign rsp_ch.pixel_out   = head_pixel_ff;
   assign rsp_ch.row_end     = head_re_ff;
   assign rsp_ch.frame_end   = head_fe_ff;
   assign rsp_ch.last_of_run = head_last_ff;

endmodule : sobel_edge_magnitude_stream_unit

`default_nettype wire

// File: rtl/sbl_checker.sv
// ----------------------------------------------------------------------------
// sbl_checker
// Port-level checks of the Sobel stream unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_pixel_out,
   input wire logic       rsp_row_end,
   input wire logic       rsp_frame_end,
   input wire logic       rsp_last_of_run
);

   // a result offered must stay offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // the row end closes the run of its pixel, and the frame end is a row end
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end && rsp_last_of_run)
      else $error("frame_end without row_end and last_of_run");

   a_row_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_end |-> rsp_last_of_run && (rsp_pixel_out == 8'd0))
      else $error("row end pixel is not a closing zero");

   // an open run is followed at once by the zero right border
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run
      |=> rsp_valid && rsp_row_end && (rsp_pixel_out == 8'd0))
      else $error("second result of a row end missing");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

endmodule : sbl_checker

bind sobel_edge_magnitude_stream_unit sbl_checker u_sbl_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_pixel_out   (rsp_ch.pixel_out),
   .rsp_row_end     (rsp_ch.row_end),
   .rsp_frame_end   (rsp_ch.frame_end),
   .rsp_last_of_run (rsp_ch.last_of_run)
);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Sobel edge magnitude stream unit: a queue-fed
// pixel driver and a result monitor with random idling on both channels, a
// per-pixel predictor of the line stores and 3x3 window, and APB register
// writes with readback between phases of different frame sizes.
// ----------------------------------------------------------------------------

module tb_top;
   import sbl_pkg::*;

   localparam int CLK_HALF     = 5;
   localparam int LINE_MAX     = 1024;
   localparam int RANDOM_ITEMS = 1600;
   localparam int DRAIN_CYCLES = 6;
   localparam int STALL_LIMIT  = 2000;

   typedef enum int {STYLE_NOISE, STYLE_EXTREME, STYLE_SMOOTH} pix_style_type;

   typedef struct packed {
      pixel_type pixel;
      logic      row_end;
      logic      frame_end;
      logic      run_last;
   } mag_result_type;

   // two frames at the clamped 3x3 size, the first saturating, then two pixels of a third
   localparam pixel_type DIRECTED_PX [20] = '{
      8'd0,   8'd0,   8'd0,   8'd0,  8'd0,  8'd255, 8'd255, 8'd255, 8'd255,
      8'd10,  8'd20,  8'd30,  8'd10, 8'd20, 8'd30,  8'd10,  8'd20,  8'd30,
      8'd255, 8'd0
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   sbl_req_if req_bus ();
   sbl_rsp_if rsp_bus ();

   sobel_edge_magnitude_stream_unit #(
      .MAX_WIDTH(LINE_MAX)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready)
   );

   always #(CLK_HALF) clock = ~clock;

   // predictor state
   logic [10:0] cfg_width  = LINE_WIDTH_RESET;
   logic [12:0] cfg_height = FRAME_HEIGHT_RESET;
   pixel_type   ls_older [LINE_MAX] = '{default: '0};
   pixel_type   ls_newer [LINE_MAX] = '{default: '0};
   pixel_type   win_px [6]          = '{default: '0};
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;

   pixel_type      pixel_q[$];
   mag_result_type pending_mags[$];

   int unsigned pix_queued    = 0;
   int unsigned pix_accepted  = 0;
   int unsigned rand_items    = 0;
   int unsigned results_seen  = 0;
   int unsigned frames_closed = 0;
   int unsigned csr_writes    = 0;
   int unsigned errors        = 0;
   int unsigned stall_cycles  = 0;
   int          smooth_level  = 128;

   logic req_took = 1'b0;
   logic rsp_took = 1'b0;
   bit   req_calm = 1'b0;
   bit   rsp_calm = 1'b0;
   int   req_wait = 0;
   int   rsp_wait = 0;

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 100) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   function automatic int unsigned eff_width();
      if (cfg_width < 3) return 3;
      if (cfg_width > LINE_MAX) return LINE_MAX;
      return cfg_width;
   endfunction

   function automatic int unsigned eff_height();
      if (cfg_height < 3) return 3;
      if (cfg_height > HEIGHT_LIMIT) return HEIGHT_LIMIT;
      return cfg_height;
   endfunction

   function automatic int draw_wait(input bit calm);
      return calm ? 0 : int'($urandom_range(0, 13));
   endfunction

   // Advance the line stores and window by one pixel and queue what it emits
   function automatic void sobel_predict(input pixel_type bot);
      int unsigned    w, h, ci;
      int             tl, ml, bl, tm, bm, top, mid, br, gx, gy, mag;
      mag_result_type res;
      w   = eff_width();
      h   = eff_height();
      ci  = col_pos % LINE_MAX;
      top = ls_older[ci];
      mid = ls_newer[ci];
      br  = bot;
      ls_older[ci] = pixel_type'(mid);
      ls_newer[ci] = bot;
      tl = win_px[0];
      ml = win_px[1];
      bl = win_px[2];
      tm = win_px[3];
      bm = win_px[5];
      gx = -tl + top - 2 * ml + 2 * mid - bl + br;
      gy = tl + 2 * tm + top - bl - 2 * bm - br;
      mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      if (mag > PIXEL_MAX) mag = PIXEL_MAX;
      if (row_pos >= 2) begin
         if (col_pos == 0) begin
            res = '{8'd0, 1'b0, 1'b0, 1'b1};
            pending_mags.push_back(res);
         end else if (col_pos >= 2 && col_pos < w - 1) begin
            res = '{pixel_type'(mag), 1'b0, 1'b0, 1'b1};
            pending_mags.push_back(res);
         end else if (col_pos == w - 1) begin
            res = '{pixel_type'(mag), 1'b0, 1'b0, 1'b0};
            pending_mags.push_back(res);
            res = '{8'd0, 1'b1, (row_pos == h - 1), 1'b1};
            pending_mags.push_back(res);
         end
      end
      win_px[0] = win_px[3];
      win_px[1] = win_px[4];
      win_px[2] = win_px[5];
      win_px[3] = pixel_type'(top);
      win_px[4] = pixel_type'(mid);
      win_px[5] = bot;
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   function automatic pixel_type make_pixel(input pix_style_type style);
      int step;
      case (style)
         STYLE_EXTREME: begin
            return ($urandom_range(0, 1) != 0) ? PIXEL_MAX : 8'd0;
         end
         STYLE_SMOOTH: begin
            step = $urandom_range(0, 6);
            smooth_level = smooth_level + step - 3;
            if (smooth_level < 0) smooth_level = 0;
            if (smooth_level > 255) smooth_level = 255;
            return pixel_type'(smooth_level);
         end
         default: begin
            return pixel_type'($urandom());
         end
      endcase
   endfunction

   function automatic void push_pixel(input pixel_type px);
      pixel_q.push_back(px);
      pix_queued++;
   endfunction

   task automatic wait_drained();
      while (pix_accepted != pix_queued || pending_mags.size() != 0) @(posedge clock);
      // pixels of rows 0 and 1 emit nothing: give the pipeline time to settle
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_read_check(input logic reg_sel);
      logic [CSR_DATA_W-1:0] got, want;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {reg_sel, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      got  = prdata;
      want = (reg_sel == REG_LINE_WIDTH) ? CSR_DATA_W'(cfg_width) : CSR_DATA_W'(cfg_height);
      if (got !== want)
         report_mismatch($sformatf("register %0d read %0d, want %0d", reg_sel, got, want));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_write(input logic reg_sel, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      // any write restarts the frame; line stores keep their contents
      if (reg_sel == REG_LINE_WIDTH) cfg_width = value[10:0];
      else cfg_height = value[12:0];
      col_pos = 0;
      row_pos = 0;
      csr_writes++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      csr_read_check(reg_sel);
   endtask

   always @(negedge clock) begin : pixel_driver
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_wait      <= 0;
      end else if (!(req_bus.valid && !req_took)) begin
         if (req_wait > 0) begin
            req_bus.valid <= 1'b0;
            req_wait      <= req_wait - 1;
         end else if (pixel_q.size() != 0) begin
            if ($urandom_range(0, 47) == 0) req_calm = !req_calm;
            req_bus.valid    <= 1'b1;
            req_bus.pixel_in <= pixel_q.pop_front();
            req_wait         <= draw_wait(req_calm);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : result_sink
      int nxt;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait      <= 0;
      end else if (rsp_took) begin
         if ($urandom_range(0, 47) == 0) rsp_calm = !rsp_calm;
         nxt = draw_wait(rsp_calm);
         rsp_wait      <= nxt;
         rsp_bus.ready <= (nxt == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait      <= rsp_wait - 1;
         rsp_bus.ready <= (rsp_wait == 1);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_monitor
      mag_result_type want;
      logic           req_fire, rsp_fire;
      req_fire = !reset && req_bus.valid === 1'b1 && req_bus.ready === 1'b1;
      rsp_fire = !reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1;
      req_took <= req_fire;
      rsp_took <= rsp_fire;
      if (rsp_fire) begin
         if (pending_mags.size() == 0) begin
            report_mismatch($sformatf("unexpected result pixel_out=%0d", rsp_bus.pixel_out));
         end else begin
            want = pending_mags.pop_front();
            if (rsp_bus.pixel_out !== want.pixel)
               report_mismatch($sformatf("result %0d pixel_out %0d, want %0d",
                                         results_seen, rsp_bus.pixel_out, want.pixel));
            if (rsp_bus.row_end !== want.row_end)
               report_mismatch($sformatf("result %0d row_end %b, want %b",
                                         results_seen, rsp_bus.row_end, want.row_end));
            if (rsp_bus.frame_end !== want.frame_end)
               report_mismatch($sformatf("result %0d frame_end %b, want %b",
                                         results_seen, rsp_bus.frame_end, want.frame_end));
            if (rsp_bus.last_of_run !== want.run_last)
               report_mismatch($sformatf("result %0d last_of_run %b, want %b",
                                         results_seen, rsp_bus.last_of_run, want.run_last));
            if (want.frame_end) frames_closed++;
         end
         results_seen++;
      end
      if (req_fire) begin
         sobel_predict(req_bus.pixel_in);
         pix_accepted++;
      end
      if (reset || req_fire || rsp_fire || (psel && penable)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin : watchdog
      wait (stall_cycles >= STALL_LIMIT);
      $display("no transfer for %0d cycles, giving up", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      int unsigned   w_sel, h_sel, n_pix, ew, eh, phase_no;
      pix_style_type style;
      bit            skip;
      req_bus.valid    = 1'b0;
      req_bus.pixel_in = '0;
      rsp_bus.ready    = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_read_check(REG_LINE_WIDTH);
      csr_read_check(REG_FRAME_HEIGHT);

      // below-range sizes run as a 3x3 frame; the third frame stops in row 0
      csr_write(REG_LINE_WIDTH, 32'd1);
      csr_write(REG_FRAME_HEIGHT, 32'd2);
      foreach (DIRECTED_PX[i]) push_pixel(DIRECTED_PX[i]);
      wait_drained();

      // an over-range width and the limit height read back raw; the first random phase rewrites both
      csr_write(REG_LINE_WIDTH, 32'hFFFF_F7FF);
      csr_write(REG_FRAME_HEIGHT, 32'(HEIGHT_LIMIT));

      phase_no = 0;
      while (rand_items < RANDOM_ITEMS) begin
         skip = (phase_no != 0) && ($urandom_range(0, 7) == 0);
         if (!skip) begin
            case ($urandom_range(0, 9))
               0:       w_sel = $urandom_range(0, 2);
               1, 2:    w_sel = $urandom_range(13, 40);
               default: w_sel = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 9))
               0:       h_sel = $urandom_range(0, 2);
               1:       h_sel = ($urandom_range(0, 1) != 0) ? 8191 : $urandom_range(4096, 8191);
               2:       h_sel = $urandom_range(9, 20);
               default: h_sel = $urandom_range(3, 8);
            endcase
            wait_drained();
            case ((phase_no == 0) ? 2 : $urandom_range(0, 3))
               0: csr_write(REG_LINE_WIDTH, ($urandom() & ~32'h7FF) | w_sel);
               1: csr_write(REG_FRAME_HEIGHT, ($urandom() & ~32'h1FFF) | h_sel);
               default: begin
                  csr_write(REG_LINE_WIDTH, ($urandom() & ~32'h7FF) | w_sel);
                  csr_write(REG_FRAME_HEIGHT, ($urandom() & ~32'h1FFF) | h_sel);
               end
            endcase
         end
         ew = eff_width();
         eh = eff_height();
         if (eh <= 20) n_pix = ew * eh * ((ew * eh <= 120) ? $urandom_range(1, 3) : 1);
         else n_pix = ew * $urandom_range(3, 8);
         // end most phases mid-frame so the next write has to restart it
         n_pix = n_pix + $urandom_range(0, 2 * ew);
         style = pix_style_type'($urandom_range(0, 2));
         repeat (n_pix) push_pixel(make_pixel(style));
         rand_items = rand_items + n_pix;
         phase_no++;
      end

      wait_drained();
      $display("covered %0d pixels over %0d random phases and %0d register writes",
               pix_accepted, phase_no, csr_writes);
      $display("checked %0d edge results, %0d frames closed, %0d mismatches",
               results_seen, frames_closed, errors);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule : tb_top
